// File: hw/rtl/fufp_pkg.sv
// Package: constants, codes and helpers for the flash update frame parser.
package fufp_pkg;

  localparam int unsigned BlockBytes    = 128;
  localparam int unsigned BlocksPerPage = 32;
  localparam int unsigned TotalPages    = 1024;
  localparam int unsigned FrameMax      = 132;
  localparam int unsigned WordsPerBlock = BlockBytes / 8;
  localparam int unsigned PageBytes     = BlockBytes * BlocksPerPage;
  localparam int unsigned AddrW         = 22;
  localparam int unsigned FsAddrW       = 8;
  localparam int unsigned SubW          = 5;
  localparam int unsigned PageShift     = 12;
  localparam int unsigned BlkShift      = 7;

  localparam logic [2:0] KindTx     = 3'd0;
  localparam logic [2:0] KindErase  = 3'd1;
  localparam logic [2:0] KindWrite  = 3'd2;
  localparam logic [2:0] KindRead   = 3'd3;
  localparam logic [2:0] KindBkCal  = 3'd4;
  localparam logic [2:0] KindBkSet  = 3'd5;
  localparam logic [2:0] KindReboot = 3'd6;

  localparam logic [7:0] CmdNop    = 8'h32;
  localparam logic [7:0] CmdBackup = 8'h35;
  localparam logic [7:0] CmdRead   = 8'h52;
  localparam logic [7:0] SubOk16   = 8'h16;
  localparam logic [7:0] SubOk10   = 8'h10;
  localparam logic [7:0] SubBackup = 8'hEE;

  localparam logic CfgOk  = 1'b0;
  localparam logic CfgNok = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [9:0] base;
    logic [10:0] span;
    logic [1:0] region;
  } region_t;

  function automatic region_t region_lookup(logic [7:0] c);
    region_t r;
    r = '{valid: 1'b1, base: 10'd0, span: 11'd0, region: 2'd0};
    case (c)
      8'h40: begin r.base = 10'h000; r.span = 11'h2D0; end
      8'h41: begin r.base = 10'h2D0; r.span = 11'h028; end
      8'h42: begin r.base = 10'h2F8; r.span = 11'h022; end
      8'h43: begin r.base = 10'h31A; r.span = 11'h002; end
      8'h47: begin r.base = 10'h3B5; r.span = 11'h00A; end
      8'h48: begin r.base = 10'h3BF; r.span = 11'h001; r.region = 2'd1; end
      8'h49: begin r.base = 10'h3C1; r.span = 11'h00A; r.region = 2'd2; end
      8'h4B: begin r.base = 10'h3D8; r.span = 11'h00A; end
      8'h4C: begin r.base = 10'h31C; r.span = 11'h099; end
      8'h57: begin r.base = 10'h000; r.span = 11'h400; end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [21:0] flash_address;
    logic [63:0] write_data;
    logic        last;
  } res_t;

endpackage

// File: hw/rtl/fufp_frame_ram.sv
// Frame store: 132 x 8 synchronous RAM, one write and one registered read port.
module fufp_frame_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [fufp_pkg::FsAddrW-1:0] waddr_i,
  input  logic [7:0]                  wdata_i,
  input  logic [fufp_pkg::FsAddrW-1:0] raddr_i,
  output logic [7:0]                  rdata_o
);
  logic [7:0] mem_q [fufp_pkg::FrameMax];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/flash_update_frame_parser_top.sv
// Top level: frame parser sequencer around the frame store RAM.
//
// channel | dir | handshake         | payload
// in      | in  | in_valid/ready    | func_i, data_byte_i
// out     | out | out_valid/ready   | kind_o .. flashing_o
// cfg     | in  | cfg_valid/ready   | cfg_index_i, cfg_data_i
//
// One item at a time. A serial beat keeps in_ready low while it is stored, its
// three header bytes are read and it is dispatched, and while its result beats go out.
// A flash return beat keeps it low while its echoed result beats go out.
// A write frame gathers each 8-byte word of its block from the frame store and
// then presents it as a write beat; a new page's block follows its erase beat.
// Each result beat waits for out_ready. Reset is asynchronous; the frame
// store needs no clearing.
module flash_update_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [21:0] flash_address_o,
  output logic [63:0] write_data_o,
  output logic        last_o,
  output logic        busy_res_o,
  output logic        flashing_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StEval  = 4'd1;
  localparam logic [3:0] StHdr1  = 4'd2;
  localparam logic [3:0] StHdr2  = 4'd3;
  localparam logic [3:0] StHdr3  = 4'd4;
  localparam logic [3:0] StDisp  = 4'd5;
  localparam logic [3:0] StEmit  = 4'd6;
  localparam logic [3:0] StGath  = 4'd7;
  localparam logic [3:0] StWord  = 4'd8;

  logic [3:0]  st_q;
  logic [7:0]  ok_q, nok_q;
  logic [7:0]  len_q, sum_q, cmd_q, b1_q, b2_q, byte_q;
  logic        good_q, func_q;
  logic [15:0] erased_q;
  logic [31:0] wmap_q;
  logic [1:0]  lreg_q;
  logic        fmode_q, run_q;
  logic [7:0]  rrem_q, rsum_q;
  logic        ram_we;
  logic [7:0]  ram_waddr, ram_raddr_q, ram_rdata;

  // result queue of up to four queued beats plus word stream
  fufp_pkg::res_t q_q [4];
  logic [2:0]  qn_q, qi_q;
  logic        reboot_q;
  logic [63:0] word_q;
  logic [3:0]  bi_q;
  logic [4:0]  wi_q;
  logic [21:0] waddr_q;
  logic [4:0]  sub_q;

  fufp_frame_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(data_byte_i),
    .raddr_i(ram_raddr_q),
    .rdata_o(ram_rdata)
  );

  logic [7:0] wlen;
  assign wlen = (len_q >= 8'(fufp_pkg::FrameMax)) ? 8'd0 : len_q;
  assign ram_we    = in_valid && in_ready && !func_i;
  assign ram_waddr = wlen;
  assign in_ready  = (st_q == StIdle);
  assign cfg_ready = 1'b1;

  function automatic fufp_pkg::res_t tx(logic [7:0] b);
    return '{kind: fufp_pkg::KindTx, tx_byte: b, flash_address: '0,
             write_data: '0, last: 1'b0};
  endfunction
  function automatic fufp_pkg::res_t ev(logic [2:0] k, logic [21:0] a);
    return '{kind: k, tx_byte: '0, flash_address: a, write_data: '0, last: 1'b0};
  endfunction

  fufp_pkg::res_t cur;
  always_comb begin
    if (st_q == StWord) begin
      cur = '{kind: fufp_pkg::KindWrite, tx_byte: '0, flash_address: waddr_q,
              write_data: word_q, last: 1'b0};
    end else begin
      cur = q_q[qi_q[1:0]];
      // an erase beat is always followed by the block's word beats
      cur.last = (qi_q + 3'd1 == qn_q) && (cur.kind != fufp_pkg::KindErase);
    end
  end
  assign out_valid       = ((st_q == StEmit) && (qn_q != 3'd0)) || (st_q == StWord);
  assign kind_o          = cur.kind;
  assign tx_byte_o       = cur.tx_byte;
  assign flash_address_o = cur.flash_address;
  assign write_data_o    = cur.write_data;
  assign last_o          = cur.last;
  assign busy_res_o      = run_q || (rrem_q != 8'd0);
  assign flashing_o      = fmode_q;

  fufp_pkg::region_t rg;
  logic [15:0] blk;
  logic [10:0] off;
  logic [10:0] page;
  assign rg   = fufp_pkg::region_lookup(cmd_q);
  assign blk  = {b1_q, b2_q};
  assign off  = blk[15:fufp_pkg::SubW];
  assign page = 11'(rg.base) + off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ok_q <= 8'd6; nok_q <= 8'd255;
      len_q <= '0; sum_q <= '0; erased_q <= 16'hFFFF; wmap_q <= '0;
      lreg_q <= '0; fmode_q <= 1'b0; run_q <= 1'b0; rrem_q <= '0; rsum_q <= '0;
      qn_q <= '0; qi_q <= '0; reboot_q <= 1'b0; ram_raddr_q <= '0;
      cmd_q <= '0; b1_q <= '0; b2_q <= '0; byte_q <= '0;
      good_q <= 1'b0; func_q <= 1'b0; bi_q <= '0; wi_q <= '0;
      word_q <= '0; waddr_q <= '0; sub_q <= '0;
      for (int i = 0; i < 4; i++) q_q[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == fufp_pkg::CfgOk) ok_q <= cfg_data_i;
        else nok_q <= cfg_data_i;
      end
      unique case (st_q)
        StIdle: if (in_valid) begin
          func_q <= func_i; byte_q <= data_byte_i; qn_q <= '0; qi_q <= '0;
          reboot_q <= 1'b0;
          if (!func_i) begin
            len_q  <= wlen + 8'd1;
            good_q <= ((len_q >= 8'(fufp_pkg::FrameMax)) ? 8'd0 : sum_q) == data_byte_i;
            sum_q  <= ((len_q >= 8'(fufp_pkg::FrameMax)) ? 8'd0 : sum_q) + data_byte_i;
            run_q  <= 1'b1;
            ram_raddr_q <= '0;
          end
          st_q <= StEval;
        end
        StEval: begin
          if (func_q) begin
            if (rrem_q != 8'd0) begin
              q_q[0] <= tx(byte_q);
              rsum_q <= rsum_q + byte_q;
              rrem_q <= rrem_q - 8'd1;
              if (rrem_q == 8'd1) begin
                q_q[1] <= tx(rsum_q + byte_q); qn_q <= 3'd2;
              end else qn_q <= 3'd1;
              st_q <= StEmit;
            end else st_q <= StIdle;
          end else begin
            ram_raddr_q <= 8'd1;
            st_q <= StHdr1;
          end
        end
        StHdr1: begin cmd_q <= ram_rdata; ram_raddr_q <= 8'd2; st_q <= StHdr2; end
        StHdr2: begin b1_q <= ram_rdata; ram_raddr_q <= 8'd3; st_q <= StHdr3; end
        StHdr3: begin b2_q <= ram_rdata; ram_raddr_q <= 8'd3; st_q <= StDisp; end
        StDisp: begin
          st_q <= StEmit;
          if (len_q == 8'd1) begin
            if (!(cmd_q == fufp_pkg::CmdNop || cmd_q == fufp_pkg::CmdBackup ||
                  cmd_q == fufp_pkg::CmdRead || rg.valid)) begin
              q_q[0] <= tx(nok_q); qn_q <= 3'd1;
              len_q <= '0; sum_q <= '0; run_q <= 1'b0;
            end
          end else if (cmd_q == fufp_pkg::CmdNop) begin
            if (len_q == 8'd5) begin
              if (!good_q) begin q_q[0] <= tx(nok_q); qn_q <= 3'd1; end
              else if (ram_rdata == fufp_pkg::SubOk16 || ram_rdata == fufp_pkg::SubOk10)
              begin q_q[0] <= tx(ok_q); qn_q <= 3'd1; end
              len_q <= '0; sum_q <= '0; run_q <= 1'b0;
            end
          end else if (cmd_q == fufp_pkg::CmdBackup) begin
            if (len_q == 8'd5) begin
              len_q <= '0; sum_q <= '0; run_q <= 1'b0;
              if (!good_q) begin q_q[0] <= tx(nok_q); qn_q <= 3'd1; end
              else if (ram_rdata == fufp_pkg::SubOk16) begin
                q_q[0] <= tx(ok_q); qn_q <= 3'd1;
              end else if (ram_rdata == fufp_pkg::SubBackup) begin
                if (fmode_q) begin
                  reboot_q <= 1'b1;
                  if (lreg_q == 2'd1 || lreg_q == 2'd2) begin
                    q_q[0] <= ev((lreg_q == 2'd1) ? fufp_pkg::KindBkCal
                                                  : fufp_pkg::KindBkSet, '0);
                    q_q[1] <= tx(ok_q);
                    q_q[2] <= ev(fufp_pkg::KindReboot, '0); qn_q <= 3'd3;
                  end else begin
                    q_q[0] <= tx(nok_q);
                    q_q[1] <= ev(fufp_pkg::KindReboot, '0); qn_q <= 3'd2;
                  end
                  erased_q <= 16'hFFFF; wmap_q <= '0; lreg_q <= '0;
                  fmode_q <= 1'b0; rrem_q <= '0; rsum_q <= '0;
                end
              end else begin q_q[0] <= tx(nok_q); qn_q <= 3'd1; end
            end
          end else if (cmd_q == fufp_pkg::CmdRead) begin
            if (len_q == 8'd4) begin
              len_q <= '0; sum_q <= '0; run_q <= 1'b0;
              if (!good_q) begin q_q[0] <= tx(nok_q); qn_q <= 3'd1; end
              else begin
                q_q[0] <= tx(cmd_q); q_q[1] <= tx(b1_q); q_q[2] <= tx(b2_q);
                q_q[3] <= ev(fufp_pkg::KindRead,
                             22'({blk, 7'd0}));
                qn_q <= 3'd4;
                rsum_q <= cmd_q + b1_q + b2_q;
                rrem_q <= 8'(fufp_pkg::BlockBytes);
              end
            end
          end else if (rg.valid) begin
            if (len_q == 8'(fufp_pkg::FrameMax)) begin
              sum_q <= '0;
              if (!good_q) begin q_q[0] <= tx(nok_q); qn_q <= 3'd1; end
              else begin
                fmode_q <= 1'b1; lreg_q <= rg.region;
                if (off >= rg.span || page >= 11'(fufp_pkg::TotalPages)) begin
                  q_q[0] <= tx(nok_q); qn_q <= 3'd1;
                end else if (16'(page) != erased_q) begin
                  q_q[0] <= ev(fufp_pkg::KindErase, 22'({page, 12'd0}));
                  qn_q <= 3'd1; erased_q <= 16'(page); wmap_q <= '0;
                  sub_q <= blk[4:0];
                  waddr_q <= 22'({page, 12'd0}) + 22'({blk[4:0], 7'd0});
                  ram_raddr_q <= 8'd3; bi_q <= '0; wi_q <= '0;
                  st_q <= StEmit;
                end else if (wmap_q[blk[4:0]]) begin
                  q_q[0] <= tx(nok_q); qn_q <= 3'd1;
                end else begin
                  sub_q <= blk[4:0];
                  waddr_q <= 22'({page, 12'd0}) + 22'({blk[4:0], 7'd0});
                  ram_raddr_q <= 8'd3; bi_q <= '0; wi_q <= '0;
                  st_q <= StGath;
                end
              end
            end
          end else begin
            q_q[0] <= tx(nok_q); qn_q <= 3'd1;
            len_q <= '0; sum_q <= '0; run_q <= 1'b0;
          end
        end
        StEmit: begin
          if (qn_q == 3'd0) st_q <= StIdle;
          else if (out_ready) begin
            if (qi_q + 3'd1 == qn_q) begin
              qn_q <= '0; qi_q <= '0;
              if (reboot_q) begin
                len_q <= '0; sum_q <= '0; run_q <= 1'b0;
              end
              st_q <= (ram_raddr_q == 8'd3 && bi_q == 4'd0 && wi_q == 5'd0 &&
                       q_q[0].kind == fufp_pkg::KindErase)
                      ? StGath : StIdle;
            end else qi_q <= qi_q + 3'd1;
          end
        end
        StGath: begin
          // RAM read data lags the address by a register; the first step of each word primes it
          ram_raddr_q <= ram_raddr_q + 8'd1;
          if (ram_raddr_q != 8'd3 + 8'({wi_q[3:0], 3'd0}) + 8'(bi_q) || bi_q != 4'd0)
          begin
            word_q <= {ram_rdata, word_q[63:8]};
            if (bi_q == 4'd8) begin
              bi_q <= '0;
              ram_raddr_q <= ram_raddr_q;
              st_q <= StWord;
            end else bi_q <= bi_q + 4'd1;
          end else bi_q <= 4'd1;
        end
        StWord: if (out_ready) begin
          waddr_q <= waddr_q + 22'd8;
          if (wi_q == 5'(fufp_pkg::WordsPerBlock - 1)) begin
            wmap_q[sub_q] <= 1'b1;
            q_q[0] <= tx(ok_q); qn_q <= 3'd1; qi_q <= '0; wi_q <= '0;
            q_q[1] <= '0;
            st_q <= StEmit;
            ram_raddr_q <= '0;
          end else begin
            wi_q <= wi_q + 5'd1;
            st_q <= StGath;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: tb/tb_flash_update_frame_parser_top.sv
// Testbench for the flash update frame parser: random and directed frames checked against a predictor.
module tb_flash_update_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    bit       func;
    bit [7:0] data;
    bit       hold;
  } beat_t;

  typedef struct {
    bit [2:0]  kind;
    bit [7:0]  tx;
    bit [21:0] addr;
    bit [63:0] wdata;
    bit        last;
    bit        busy;
    bit        fl;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [21:0] flash_address_o;
  logic [63:0] write_data_o;
  logic        last_o;
  logic        busy_res_o;
  logic        flashing_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index_i = fufp_pkg::CfgOk;
  logic [7:0]  cfg_data_i = '0;

  flash_update_frame_parser_top uut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  bit [7:0]  frame_q [fufp_pkg::FrameMax];
  bit [7:0]  frame_len, sum_acc, echo_sum, echo_left;
  bit [15:0] open_page;
  bit [31:0] done_blocks;
  bit [1:0]  region_seen;
  bit        flash_on, in_cmd;
  bit [7:0]  ok_byte = 8'd6, nok_byte = 8'd255;

  beat_t    stim_q [$];
  outcome_t expected_q [$];
  outcome_t step_q [$];
  int errors = 0, n_in = 0, n_out = 0, n_writes = 0, n_reboots = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  longint cycles = 0;

  function automatic bit region_of(input bit [7:0] c, output int unsigned base,
                                   output int unsigned span, output bit [1:0] reg_id);
    reg_id = 2'd0;
    case (c)
      8'h40: begin base = 'h000; span = 'h2D0; end
      8'h41: begin base = 'h2D0; span = 'h028; end
      8'h42: begin base = 'h2F8; span = 'h022; end
      8'h43: begin base = 'h31A; span = 'h002; end
      8'h47: begin base = 'h3B5; span = 'h00A; end
      8'h48: begin base = 'h3BF; span = 'h001; reg_id = 2'd1; end
      8'h49: begin base = 'h3C1; span = 'h00A; reg_id = 2'd2; end
      8'h4B: begin base = 'h3D8; span = 'h00A; end
      8'h4C: begin base = 'h31C; span = 'h099; end
      8'h57: begin base = 'h000; span = 'h400; end
      default: begin base = 0; span = 0; return 1'b0; end
    endcase
    return 1'b1;
  endfunction

  function automatic void emit(bit [2:0] k, bit [7:0] tx, bit [21:0] a, bit [63:0] d);
    outcome_t o;
    o = '{kind: k, tx: tx, addr: a, wdata: d, last: 0, busy: 0, fl: 0};
    step_q.push_back(o);
  endfunction

  function automatic void clear_parser();
    frame_len = 0; sum_acc = 0; open_page = 16'hFFFF; done_blocks = 0;
    region_seen = 0; flash_on = 0; in_cmd = 0; echo_left = 0; echo_sum = 0;
  endfunction

  function automatic void close_frame(bit drop_cmd);
    frame_len = 0; sum_acc = 0;
    if (drop_cmd) in_cmd = 0;
  endfunction

  function automatic void program_block(bit [7:0] c);
    int unsigned base, span, blk, off, sub, page;
    bit [1:0] reg_id;
    bit [21:0] a;
    bit [63:0] d;
    blk = {frame_q[1], frame_q[2]};
    off = blk / fufp_pkg::BlocksPerPage;
    sub = blk % fufp_pkg::BlocksPerPage;
    flash_on = 1;
    void'(region_of(c, base, span, reg_id));
    region_seen = reg_id;
    if (off >= span || base + off >= fufp_pkg::TotalPages) begin
      emit(fufp_pkg::KindTx, nok_byte, 0, 0);
      return;
    end
    page = base + off;
    if (page != open_page) begin
      emit(fufp_pkg::KindErase, 0, 22'(page * fufp_pkg::PageBytes), 0);
      open_page = 16'(page);
      done_blocks = 0;
    end else if (done_blocks[sub]) begin
      emit(fufp_pkg::KindTx, nok_byte, 0, 0);
      return;
    end
    a = 22'(page * fufp_pkg::PageBytes + sub * fufp_pkg::BlockBytes);
    for (int w = 0; w < fufp_pkg::WordsPerBlock; w++) begin
      for (int i = 0; i < 8; i++) d[8*i +: 8] = frame_q[3 + 8*w + i];
      emit(fufp_pkg::KindWrite, 0, 22'(a + 8*w), d);
    end
    done_blocks[sub] = 1;
    emit(fufp_pkg::KindTx, ok_byte, 0, 0);
  endfunction

  function automatic void take_serial(bit [7:0] b);
    bit [7:0] prior, c;
    bit good, dummy;
    int unsigned x, y;
    bit [1:0] z;
    if (frame_len >= fufp_pkg::FrameMax) close_frame(0);
    frame_q[frame_len] = b;
    frame_len++;
    prior = sum_acc;
    sum_acc += b;
    in_cmd = 1;
    c = frame_q[0];
    good = (prior == b);
    dummy = region_of(c, x, y, z);
    if (frame_len == 1) begin
      if (!(c == fufp_pkg::CmdBackup || c == fufp_pkg::CmdNop || c == fufp_pkg::CmdRead ||
            dummy)) begin
        emit(fufp_pkg::KindTx, nok_byte, 0, 0);
        close_frame(1);
      end
    end else if (c == fufp_pkg::CmdNop) begin
      if (frame_len == 5) begin
        if (!good) emit(fufp_pkg::KindTx, nok_byte, 0, 0);
        else if (frame_q[3] == fufp_pkg::SubOk16 || frame_q[3] == fufp_pkg::SubOk10)
          emit(fufp_pkg::KindTx, ok_byte, 0, 0);
        close_frame(1);
      end
    end else if (c == fufp_pkg::CmdBackup) begin
      if (frame_len == 5) begin
        if (!good) begin
          emit(fufp_pkg::KindTx, nok_byte, 0, 0);
          close_frame(1);
        end else if (frame_q[3] == fufp_pkg::SubOk16) begin
          emit(fufp_pkg::KindTx, ok_byte, 0, 0);
          close_frame(1);
        end else if (frame_q[3] == fufp_pkg::SubBackup) begin
          if (!flash_on) close_frame(1);
          else begin
            if (region_seen == 2'd1) begin
              emit(fufp_pkg::KindBkCal, 0, 0, 0); emit(fufp_pkg::KindTx, ok_byte, 0, 0);
            end else if (region_seen == 2'd2) begin
              emit(fufp_pkg::KindBkSet, 0, 0, 0); emit(fufp_pkg::KindTx, ok_byte, 0, 0);
            end else begin
              emit(fufp_pkg::KindTx, nok_byte, 0, 0);
            end
            emit(fufp_pkg::KindReboot, 0, 0, 0);
            n_reboots++;
            clear_parser();
          end
        end else begin
          emit(fufp_pkg::KindTx, nok_byte, 0, 0);
          close_frame(1);
        end
      end
    end else if (c == fufp_pkg::CmdRead) begin
      if (frame_len == 4) begin
        if (!good) emit(fufp_pkg::KindTx, nok_byte, 0, 0);
        else begin
          emit(fufp_pkg::KindTx, c, 0, 0);
          emit(fufp_pkg::KindTx, frame_q[1], 0, 0);
          emit(fufp_pkg::KindTx, frame_q[2], 0, 0);
          emit(fufp_pkg::KindRead, 0,
               22'({frame_q[1], frame_q[2]} * fufp_pkg::BlockBytes), 0);
          echo_sum = c + frame_q[1] + frame_q[2];
          echo_left = 8'(fufp_pkg::BlockBytes);
        end
        close_frame(1);
      end
    end else if (frame_len == fufp_pkg::FrameMax) begin
      if (!good) emit(fufp_pkg::KindTx, nok_byte, 0, 0);
      else begin
        program_block(c);
        n_writes++;
      end
      close_frame(0);
    end
  endfunction

  function automatic void predict(bit f, bit [7:0] b);
    step_q.delete();
    if (!f) take_serial(b);
    else if (echo_left != 0) begin
      emit(fufp_pkg::KindTx, b, 0, 0);
      echo_sum += b;
      echo_left--;
      if (echo_left == 0) emit(fufp_pkg::KindTx, echo_sum, 0, 0);
    end
    foreach (step_q[k]) begin
      step_q[k].last = (k == step_q.size() - 1);
      step_q[k].busy = in_cmd || echo_left != 0;
      step_q[k].fl = flash_on;
      expected_q.push_back(step_q[k]);
    end
  endfunction

  // stimulus builders
  task automatic add_frame(input bit [7:0] hdr [$], input bit bad, input bit hold = 0);
    bit [7:0] s = 0;
    foreach (hdr[i]) begin
      stim_q.push_back('{0, hdr[i], hold && i == 0});
      s += hdr[i];
    end
    if (bad) s ^= 8'($urandom_range(1, 255));
    stim_q.push_back('{0, s, 0});
  endtask

  task automatic add_returns(int n);
    repeat (n) stim_q.push_back('{1, 8'($urandom), 0});
  endtask

  task automatic add_write(bit [7:0] c, bit [15:0] blk, bit bad = 0);
    bit [7:0] h [$];
    h = '{c, blk[15:8], blk[7:0]};
    repeat (fufp_pkg::BlockBytes) h.push_back(8'($urandom));
    add_frame(h, bad);
  endtask

  task automatic add_short(bit [7:0] c, bit [7:0] sub, bit bad = 0);
    add_frame('{c, 8'($urandom), 8'($urandom), sub}, bad);
  endtask

  task automatic add_random(int frames);
    bit [7:0] c, sub;
    int unsigned base, span, sel;
    bit [1:0] r;
    bit [15:0] blk;
    repeat (frames) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        case ($urandom_range(0, 2))
          0: sub = fufp_pkg::SubOk16;
          1: sub = fufp_pkg::SubOk10;
          default: sub = 8'($urandom);
        endcase
        add_short(fufp_pkg::CmdNop, sub, $urandom_range(0, 9) == 0);
      end else if (sel < 50) begin
        case ($urandom_range(0, 2))
          0: sub = fufp_pkg::SubOk16;
          1: sub = fufp_pkg::SubBackup;
          default: sub = 8'($urandom);
        endcase
        add_short(fufp_pkg::CmdBackup, sub, $urandom_range(0, 9) == 0);
      end else if (sel < 75) begin
        blk = 16'($urandom);
        add_frame('{fufp_pkg::CmdRead, blk[15:8], blk[7:0]}, $urandom_range(0, 9) == 0);
        add_returns($urandom_range(0, 6));
      end else if (sel < 90) begin
        do c = 8'($urandom);
        while (c == fufp_pkg::CmdNop || c == fufp_pkg::CmdBackup ||
               c == fufp_pkg::CmdRead || region_of(c, base, span, r));
        stim_q.push_back('{0, c, 0});
      end else begin
        add_returns($urandom_range(1, 4));
      end
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [0:0] idx, bit [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct &&
            (!stim_q[0].hold || (expected_q.size() == 0 && !in_valid))) begin
          in_valid <= 1'b1;
          func_i <= stim_q[0].func;
          data_byte_i <= stim_q[0].data;
          void'(stim_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == fufp_pkg::CfgOk) ok_byte = cfg_data_i;
        else nok_byte = cfg_data_i;
      end
      if (in_valid && in_ready) begin
        n_in++;
        predict(func_i, data_byte_i);
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind=%0d tx=%02h", $time, kind_o, tx_byte_o);
        end else begin
          e = expected_q.pop_front();
          if (kind_o !== e.kind || tx_byte_o !== e.tx || flash_address_o !== e.addr ||
              write_data_o !== e.wdata || last_o !== e.last || busy_res_o !== e.busy ||
              flashing_o !== e.fl) begin
            errors++;
            $display("%0t: mismatch exp kind=%0d tx=%02h addr=%06h data=%016h l=%b b=%b f=%b",
                     $time, e.kind, e.tx, e.addr, e.wdata, e.last, e.busy, e.fl);
            $display("%0t:          got kind=%0d tx=%02h addr=%06h data=%016h l=%b b=%b f=%b",
                     $time, kind_o, tx_byte_o, flash_address_o, write_data_o, last_o,
                     busy_res_o, flashing_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("flash_update_frame_parser_top verification failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 8;
    rx_idle_pct = 67;
    add_short(fufp_pkg::CmdNop, fufp_pkg::SubOk16);
    stim_q.push_back('{0, 8'h00, 0});
    add_short(fufp_pkg::CmdBackup, fufp_pkg::SubBackup);
    add_returns(1);
    add_frame('{fufp_pkg::CmdRead, 8'hFF, 8'hFF}, 0);
    add_returns(3);
    add_short(fufp_pkg::CmdNop, fufp_pkg::SubOk10, 1);
    add_short(fufp_pkg::CmdNop, fufp_pkg::SubOk10, 0);
    stim_q[stim_q.size() - 5].hold = 1;
    wait_drained();

    write_reg(fufp_pkg::CfgOk, 8'h00);
    write_reg(fufp_pkg::CfgNok, 8'h00);
    tx_idle_pct = 67;
    rx_idle_pct = 8;
    add_write(8'h48, 16'h001F);
    add_short(fufp_pkg::CmdBackup, fufp_pkg::SubBackup);
    wait_drained();

    write_reg(fufp_pkg::CfgOk, 8'hFF);
    write_reg(fufp_pkg::CfgNok, 8'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_random(3);
    wait_drained();

    $display("Covered %0d input beats, %0d result beats, %0d write frames, %0d reboots,",
             n_in, n_out, n_writes, n_reboots);
    $display("over three idling patterns and three reply code settings.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("flash_update_frame_parser_top verification clean");
    end else begin
      $display("flash_update_frame_parser_top verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/fufp_pkg.sv
hw/rtl/fufp_frame_ram.sv
hw/rtl/flash_update_frame_parser_top.sv
tb/tb_flash_update_frame_parser_top.sv
